### hdl/multi_queue_shared_buffer_macros.svh
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_macros: assertion macros
// concurrent assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef MULTI_QUEUE_SHARED_BUFFER_MACROS_SVH
`define MULTI_QUEUE_SHARED_BUFFER_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define MQSB_ASSERT_NOW(lbl, clk_, rstn_, ante, cons, msg) \
    lbl: assert property (@(posedge clk_) disable iff (!rstn_) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define MQSB_ASSERT_NEXT(lbl, clk_, rstn_, ante, cons, msg) \
    lbl: assert property (@(posedge clk_) disable iff (!rstn_) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg: shared definitions
// constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int MQSB_ENTRIES = 16;
    localparam int MQSB_QUEUES  = 4;

    localparam int QID_W  = 2;
    localparam int WORD_W = 32;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } mqsb_status_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;       // take the request, start first reads
        logic issue_fetch;   // read payload and link at the queue head
        logic commit_look;   // finish enqueue or any refused request
        logic commit_fetch;  // finish a dequeue
    } mqsb_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_deq;
        logic req_err;
        logic out_free;
    } mqsb_stat_t;

endpackage

### hdl/mqsb_ram.sv
// ----------------------------------------------------------------------------
// mqsb_ram: generic single-port-write ram
// one write and one read port, registered read data
// ----------------------------------------------------------------------------
module mqsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mqsb_ctrl.sv
// ----------------------------------------------------------------------------
// mqsb_ctrl: request sequencer
// steps one request through lookup, optional fetch and commit
// ----------------------------------------------------------------------------
module mqsb_ctrl
    import mqsb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mqsb_stat_t stat,
    output mqsb_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_LOOK  = 3'b010,
        S_FETCH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOK;
                end
            end
            S_LOOK:
            begin
                // a good dequeue still needs payload and link of the head
                if (stat.is_deq && !stat.req_err)
                begin
                    cmd.issue_fetch = 1'b1;
                    state_next      = S_FETCH;
                end
                else if (stat.out_free)
                begin
                    cmd.commit_look = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_FETCH:
            begin
                if (stat.out_free)
                begin
                    cmd.commit_fetch = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/mqsb_dp.sv
// ----------------------------------------------------------------------------
// mqsb_dp: queue datapath
// payload, link, head and tail stores, free list and output register
// ----------------------------------------------------------------------------
module mqsb_dp
    import mqsb_pkg::*;
#(
    parameter int ENTRIES = MQSB_ENTRIES,
    parameter int QUEUES  = MQSB_QUEUES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mqsb_cmd_t                cmd,
    output mqsb_stat_t               stat,
    input  logic                     req_type,
    input  logic [QID_W-1:0]         queue_id,
    input  logic signed [WORD_W-1:0] write_data,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] read_data,
    output logic [1:0]               status
);

    localparam int PTR_W = $clog2(ENTRIES + 1);  // holds the null code ENTRIES
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int QA_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [PTR_W-1:0] NIL = PTR_W'(ENTRIES);

    // request registers
    logic                  type_reg;
    logic [QID_W-1:0]      q_reg;
    logic [WORD_W-1:0]     wdata_reg;

    // list control
    logic [PTR_W-1:0]      free_head_reg, free_head_next;
    logic [PTR_W-1:0]      hwm_reg, hwm_next;       // entries below this were allocated at least once
    logic [QUEUES-1:0]     ne_reg, ne_next;          // queue holds at least one word
    logic [IDX_W-1:0]      link_raddr_reg;

    // output register
    logic                  out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]     read_data_reg, read_data_next;
    mqsb_status_t          status_reg, status_next;

    // ram ports
    logic                  pay_we, pay_re;
    logic [IDX_W-1:0]      pay_waddr;
    logic [WORD_W-1:0]     pay_rdata;
    logic                  link_we, link_re;
    logic [IDX_W-1:0]      link_waddr, link_raddr;
    logic [PTR_W-1:0]      link_wdata, link_rdata;
    logic                  head_we, hq_re;
    logic [QA_W-1:0]       q_raddr, qa;
    logic [IDX_W-1:0]      head_wdata, head_rdata, tail_rdata;
    logic                  tail_we;

    logic                  q_ok, fh_ok, ne_cur, is_deq, req_err;
    logic                  enq_ok, deq_ok;
    logic [IDX_W-1:0]      slot;
    logic [PTR_W-1:0]      link_eff;

    assign qa      = QA_W'(q_reg);
    assign q_raddr = QA_W'(queue_id);
    assign is_deq  = (type_reg == REQ_DEQ);
    assign q_ok    = (32'(q_reg) < 32'(QUEUES));
    assign fh_ok   = (free_head_reg < NIL);
    assign ne_cur  = q_ok ? ne_reg[qa] : 1'b0;
    assign req_err = is_deq ? !(q_ok && ne_cur) : !(q_ok && fh_ok);
    assign slot    = free_head_reg[IDX_W-1:0];

    // an entry never allocated reads as its reset value i+1, the last one as null
    assign link_eff = (PTR_W'(link_raddr_reg) >= hwm_reg)
                      ? (PTR_W'(link_raddr_reg) + PTR_W'(1)) : link_rdata;

    assign enq_ok = cmd.commit_look && !is_deq && !req_err;
    assign deq_ok = cmd.commit_fetch;

    // read side
    assign hq_re      = cmd.capture;
    assign pay_re     = cmd.issue_fetch;
    assign link_re    = cmd.capture || cmd.issue_fetch;
    assign link_raddr = cmd.issue_fetch ? head_rdata : slot;

    // write side
    assign pay_we     = enq_ok;
    assign pay_waddr  = slot;
    assign tail_we    = enq_ok;
    assign head_we    = (enq_ok && !ne_cur) || deq_ok;
    assign head_wdata = deq_ok ? link_eff[IDX_W-1:0] : slot;
    assign link_we    = (enq_ok && ne_cur) || deq_ok;
    assign link_waddr = deq_ok ? head_rdata : tail_rdata;
    assign link_wdata = deq_ok ? free_head_reg : PTR_W'(slot);

    mqsb_ram #(.WIDTH(WORD_W), .DEPTH(ENTRIES)) u_payload (
        .clk   (clk),
        .we    (pay_we),
        .waddr (pay_waddr),
        .wdata (wdata_reg),
        .re    (pay_re),
        .raddr (head_rdata),
        .rdata (pay_rdata)
    );

    mqsb_ram #(.WIDTH(PTR_W), .DEPTH(ENTRIES)) u_link (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    mqsb_ram #(.WIDTH(IDX_W), .DEPTH(QUEUES)) u_head (
        .clk   (clk),
        .we    (head_we),
        .waddr (qa),
        .wdata (head_wdata),
        .re    (hq_re),
        .raddr (q_raddr),
        .rdata (head_rdata)
    );

    mqsb_ram #(.WIDTH(IDX_W), .DEPTH(QUEUES)) u_tail (
        .clk   (clk),
        .we    (tail_we),
        .waddr (qa),
        .wdata (slot),
        .re    (hq_re),
        .raddr (q_raddr),
        .rdata (tail_rdata)
    );

    always_comb
    begin
        free_head_next = free_head_reg;
        hwm_next       = hwm_reg;
        ne_next        = ne_reg;
        if (enq_ok)
        begin
            free_head_next = link_eff;
            ne_next[qa]    = 1'b1;
            if (free_head_reg >= hwm_reg)
            begin
                hwm_next = free_head_reg + PTR_W'(1);
            end
        end
        if (deq_ok)
        begin
            free_head_next = PTR_W'(head_rdata);
            ne_next[qa]    = (head_rdata != tail_rdata);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        if (cmd.commit_look)
        begin
            out_valid_next = 1'b1;
            read_data_next = (is_deq && req_err) ? '1 : '0;
            if (!req_err)
            begin
                status_next = ST_DONE;
            end
            else if (is_deq)
            begin
                status_next = ST_UNDER;
            end
            else
            begin
                status_next = ST_OVER;
            end
        end
        if (cmd.commit_fetch)
        begin
            out_valid_next = 1'b1;
            read_data_next = pay_rdata;
            status_next    = ST_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            hwm_reg       <= '0;
            ne_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            free_head_reg <= free_head_next;
            hwm_reg       <= hwm_next;
            ne_reg        <= ne_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg  <= req_type;
            q_reg     <= queue_id;
            wdata_reg <= write_data;
        end
        if (link_re)
        begin
            link_raddr_reg <= link_raddr;
        end
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
    end

    assign stat.is_deq   = is_deq;
    assign stat.req_err  = req_err;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status    = status_reg;

endmodule

### hdl/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer: several fifo queues in one shared store
// linked-list queues over a common payload ram with a free list
// ----------------------------------------------------------------------------
// QUEUES fifo queues share one store of ENTRIES 32-bit words. Entries are
// chained through a link ram and idle entries wait on a free list. One request
// is handled at a time and each request gives exactly one result word. An
// enqueue, and any refused request, passes through the lookup state and loads
// the result register when leaving it, once the output register is free; a
// dequeue also passes through a fetch state, since the queue head must come out
// of its ram before payload and link can be read at it. A result word that is
// not taken stalls the next result, never the acceptance itself: in_ready
// returns in the cycle the result word appears in the output register, even if
// that word is still waiting to be taken. An enqueue to a full store gives
// status overflow with read_data 0; a dequeue from an empty queue gives status
// underflow with read_data -1; a queue number not below QUEUES is refused in
// the same way. No clearing pass is needed after reset: link entries that
// were never allocated read back their reset value through a high-water mark.
// ----------------------------------------------------------------------------
module multi_queue_shared_buffer
    import mqsb_pkg::*;
#(
    parameter int ENTRIES = MQSB_ENTRIES,  // 2 .. 4096
    parameter int QUEUES  = MQSB_QUEUES    // 1 .. 4, queue_id is QID_W = 2 bits wide
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // request channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic [QID_W-1:0]         queue_id,
    input  logic signed [WORD_W-1:0] write_data,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] read_data,
    output logic [1:0]               status
);

    mqsb_cmd_t  cmd;   // sequencer commands to the datapath
    mqsb_stat_t stat;  // request decode and output-register state back

    // sequencer: idle, lookup of heads/tails/free link, optional payload fetch
    mqsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: all stores, free-list pointer and the result register
    mqsb_dp #(
        .ENTRIES (ENTRIES),
        .QUEUES  (QUEUES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .queue_id   (queue_id),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .status     (status)
    );

endmodule

### hdl/mqsb_checker.sv
// ----------------------------------------------------------------------------
// mqsb_checker: port-level checks
// watches the top-level handshakes and result codes
// ----------------------------------------------------------------------------
`include "multi_queue_shared_buffer_macros.svh"

module mqsb_checker
    import mqsb_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [WORD_W-1:0] read_data,
    input logic [1:0]               status
);

    // a stalled result word holds
`MQSB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(status), "result word changed while stalled")

    // one request in flight: no acceptance in the cycle after one
`MQSB_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while another is in work")

    // underflow always returns all ones
`MQSB_ASSERT_NOW(a_under_data, clk, rst_n, out_valid && (status == ST_UNDER), read_data == -32'sd1, "underflow without -1 data")

    // overflow always returns zero
`MQSB_ASSERT_NOW(a_over_data, clk, rst_n, out_valid && (status == ST_OVER), read_data == 32'sd0, "overflow with non-zero data")

endmodule

bind multi_queue_shared_buffer mqsb_checker u_mqsb_checker (.*);

### test/tb_multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// tb_multi_queue_shared_buffer: self-checking bench for the shared queue store
// drives enqueue and dequeue words under varying idle and stall patterns and
// compares every result word with a linked-list model held in a scoreboard
// ----------------------------------------------------------------------------
module tb_multi_queue_shared_buffer;
    import mqsb_pkg::*;

    localparam int PTR_W       = $clog2(MQSB_ENTRIES + 1);
    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake on either side
    localparam int RAND_PER_PHASE = 332;

    typedef logic [PTR_W-1:0] ptr_t;

    typedef struct {
        logic signed [WORD_W-1:0] data;
        mqsb_status_t             st;
    } reply_t;

    // scoreboard: own copy of the linked store, plus the replies still owed
    class shared_queue_checker;
        logic signed [WORD_W-1:0] word_ram [MQSB_ENTRIES];
        ptr_t                     next_ptr [MQSB_ENTRIES];
        ptr_t                     head_ptr [MQSB_QUEUES];
        ptr_t                     tail_ptr [MQSB_QUEUES];
        ptr_t                     free_ptr;
        int                       depth [MQSB_QUEUES];
        int                       in_use;
        reply_t                   owed_replies [$];
        int n_enq, n_deq, n_over, n_under, n_checked, n_fail;

        function new();
            for (int i = 0; i < MQSB_ENTRIES; i++)
            begin
                word_ram[i] = '0;
                next_ptr[i] = ptr_t'(i + 1);  // the last one lands on null
            end
            for (int q = 0; q < MQSB_QUEUES; q++)
            begin
                head_ptr[q] = ptr_t'(MQSB_ENTRIES);
                tail_ptr[q] = ptr_t'(MQSB_ENTRIES);
                depth[q]    = 0;
            end
            free_ptr = '0;
            in_use   = 0;
            n_enq = 0; n_deq = 0; n_over = 0; n_under = 0; n_checked = 0; n_fail = 0;
        endfunction

        // apply one accepted request word to the model and queue its reply
        function void note_request(logic kind, logic [QID_W-1:0] qid,
                                   logic signed [WORD_W-1:0] data);
            reply_t r;
            ptr_t   slot;
            r.data = '0;
            r.st   = ST_DONE;
            if (kind == REQ_ENQ)
            begin
                n_enq++;
                if (int'(qid) >= MQSB_QUEUES || free_ptr >= MQSB_ENTRIES)
                begin
                    r.st = ST_OVER;
                    n_over++;
                end
                else
                begin
                    slot     = free_ptr;
                    free_ptr = next_ptr[slot];
                    if (head_ptr[qid] >= MQSB_ENTRIES)
                        head_ptr[qid] = slot;
                    else if (tail_ptr[qid] < MQSB_ENTRIES)
                        next_ptr[tail_ptr[qid]] = slot;
                    next_ptr[slot] = ptr_t'(MQSB_ENTRIES);
                    tail_ptr[qid]  = slot;
                    word_ram[slot] = data;
                    depth[qid]++;
                    in_use++;
                end
            end
            else
            begin
                n_deq++;
                if (int'(qid) >= MQSB_QUEUES || head_ptr[qid] >= MQSB_ENTRIES)
                begin
                    r.data = -1;
                    r.st   = ST_UNDER;
                    n_under++;
                end
                else
                begin
                    slot           = head_ptr[qid];
                    r.data         = word_ram[slot];
                    head_ptr[qid]  = next_ptr[slot];
                    next_ptr[slot] = free_ptr;
                    free_ptr       = slot;
                    depth[qid]--;
                    in_use--;
                end
            end
            owed_replies.push_back(r);
        endfunction

        // compare one accepted result word with the oldest owed reply
        function void check_reply(logic signed [WORD_W-1:0] data, logic [1:0] st);
            reply_t r;
            if (owed_replies.size() == 0)
            begin
                $error("result word with nothing outstanding: read_data %0d status %0d",
                       data, st);
                n_fail++;
                return;
            end
            r = owed_replies.pop_front();
            n_checked++;
            if (data !== r.data)
            begin
                $error("read_data: expected %0d, got %0d", r.data, data);
                n_fail++;
            end
            if (st !== r.st)
            begin
                $error("status: expected %0d, got %0d", r.st, st);
                n_fail++;
            end
        endfunction
    endclass

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic                     req_type   = REQ_ENQ;
    logic [QID_W-1:0]         queue_id   = '0;
    logic signed [WORD_W-1:0] write_data = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [WORD_W-1:0] read_data;
    logic [1:0]               status;

    shared_queue_checker shadow = new();

    int  send_idle_pct = 0;  // chance in a hundred that the sender sits idle a cycle
    int  stall_pct     = 0;  // chance in a hundred that the receiver holds off a cycle
    int  quiet_cycles  = 0;
    bit  filling       = 1'b1;

    always #2 clk = ~clk;

    multi_queue_shared_buffer i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .queue_id   (queue_id),
        .write_data (write_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .status     (status)
    );

    // result side: take a word when both sides agree, then pick next cycle's ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            shadow.check_reply(read_data, status);
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // watchdog: a long stretch with no handshake anywhere means the block hung
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // offer one request word, with random idle cycles in front, and hold it
    // steady until it is taken
    task automatic send_request(input logic kind, input logic [QID_W-1:0] qid,
                                input logic signed [WORD_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= kind;
        queue_id   <= qid;
        write_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        shadow.note_request(kind, qid, data);
    endtask

    // random request: mostly fill-then-drain sweeps so the free list and the
    // links get churned, with a share of plain noise on top
    task automatic send_random_request();
        logic             kind;
        logic [QID_W-1:0] qid;
        if (shadow.in_use == MQSB_ENTRIES)
            filling = 1'b0;
        else if (shadow.in_use == 0)
            filling = 1'b1;
        qid = QID_W'($urandom_range(MQSB_QUEUES - 1));
        if ($urandom_range(99) < 8)
            kind = logic'($urandom_range(1));
        else if (filling)
            kind = ($urandom_range(99) < 80) ? REQ_ENQ : REQ_DEQ;
        else
        begin
            kind = ($urandom_range(99) < 80) ? REQ_DEQ : REQ_ENQ;
            // steer most dequeues at a queue that holds something
            if (kind == REQ_DEQ && shadow.in_use > 0 && $urandom_range(9) < 8)
                while (shadow.depth[qid] == 0)
                    qid = QID_W'($urandom_range(MQSB_QUEUES - 1));
        end
        send_request(kind, qid, $urandom);
    endtask

    initial
    begin
        int idle_plan  [4];
        int stall_plan [4];
        idle_plan  = '{0, 76, 0, 37};
        stall_plan = '{0, 0, 76, 37};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part: empty queue, field extremes, fill to overflow, one dequeue per queue
        send_request(REQ_DEQ, 2'd0, 32'sh1234_5678);
        send_request(REQ_ENQ, 2'd0, 32'sh7fff_ffff);
        send_request(REQ_ENQ, 2'd1, 32'sh8000_0000);
        send_request(REQ_ENQ, 2'd2, -32'sd1);
        send_request(REQ_ENQ, 2'd3, 32'sd0);
        for (int i = 0; i < MQSB_ENTRIES - 4; i++)
            send_request(REQ_ENQ, QID_W'(i % MQSB_QUEUES), $urandom);
        // store now full
        send_request(REQ_ENQ, 2'd3, 32'sh5555_aaaa);
        send_request(REQ_DEQ, 2'd0, 32'shffff_ffff);
        send_request(REQ_DEQ, 2'd1, 32'sd0);
        send_request(REQ_DEQ, 2'd2, 32'sh0f0f_0f0f);
        send_request(REQ_DEQ, 2'd3, 32'sh8000_0000);

        // random part, one phase per idle and stall pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_plan[ph];
            stall_pct     = stall_plan[ph];
            repeat (RAND_PER_PHASE) send_random_request();
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        while (shadow.owed_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d enqueues (%0d overflow) and %0d dequeues (%0d underflow)",
                 shadow.n_enq, shadow.n_over, shadow.n_deq, shadow.n_under);
        $display("%0d result words checked, %0d mismatches",
                 shadow.n_checked, shadow.n_fail);
        if (shadow.n_fail == 0 && shadow.owed_replies.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
